>>> design/text_console_buffer_macros.svh
// assertion macros for the text console buffer
`ifndef TEXT_CONSOLE_BUFFER_MACROS_SVH
`define TEXT_CONSOLE_BUFFER_MACROS_SVH

// same-cycle implication, clocked on i_clk, off during reset
`define TCB_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, clocked on i_clk, off during reset
`define TCB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/tcb_pkg.sv
package tcb_pkg;

    // grid geometry
    localparam int COLUMNS = 50;
    localparam int ROWS    = 20;
    localparam int CELLS   = ROWS * COLUMNS;

    // internal widths
    localparam int ADDR_W = $clog2(CELLS);
    localparam int COL_W  = $clog2(COLUMNS);
    localparam int ROW_W  = $clog2(ROWS);

    // port field widths
    localparam int CHAR_W    = 8;
    localparam int OP_W      = 2;
    localparam int OUT_ROW_W = 5;
    localparam int OUT_COL_W = 6;

    // character codes
    localparam logic [CHAR_W-1:0] SPACE_CHAR   = 8'h20;
    localparam logic [CHAR_W-1:0] NEWLINE_CHAR = 8'h0a;
    localparam logic [CHAR_W-1:0] NUL_CHAR     = 8'h00;

    // operation codes
    typedef enum logic [OP_W-1:0] {
        OP_PUT  = 2'd0,
        OP_READ = 2'd1,
        OP_TAKE = 2'd2
    } t_op;

    // controller states
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_TAKE,
        ST_COPY,
        ST_FILL
    } t_state;

endpackage

>>> design/tcb_ram.sv
module tcb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1000
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> design/text_console_buffer.sv
// channel   handshake               payload
// command   start / busy            i_operation, i_char_code, i_row_select, i_column_select
// result    o_done (one cycle)      o_cell_char, o_dirty_row, o_dirty_found,
//                                   o_cursor_column, o_cursor_row
//
// put without scroll, undefined op, zero byte, out-of-range read: result in the cycle after accept
// read in range: result through ST_READ and the registered ram read
// take: the dirty marks are scanned one row per cycle
// scroll: copy rows up (each cell read, then written one row up), then blank the last row
// after reset the ram is filled with spaces, all CELLS cells (1000), with busy high
// the receiver cannot stall; busy alone holds off new items
`include "text_console_buffer_macros.svh"

module text_console_buffer import tcb_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [OP_W-1:0]      i_operation,
    input  logic [CHAR_W-1:0]    i_char_code,
    input  logic [OUT_ROW_W-1:0] i_row_select,
    input  logic [OUT_COL_W-1:0] i_column_select,
    output logic                 o_done,
    output logic [CHAR_W-1:0]    o_cell_char,
    output logic [OUT_ROW_W-1:0] o_dirty_row,
    output logic                 o_dirty_found,
    output logic [OUT_COL_W-1:0] o_cursor_column,
    output logic [OUT_ROW_W-1:0] o_cursor_row
);

    t_state              r_state,    n_state;
    logic [ADDR_W-1:0]   r_ptr,      n_ptr;
    logic                r_pend,     n_pend;
    logic [ADDR_W-1:0]   r_paddr,    n_paddr;
    logic [ROW_W-1:0]    r_idx,      n_idx;
    logic [ROWS-1:0]     r_dirty,    n_dirty;
    logic [COL_W-1:0]    r_cur_col,  n_cur_col;
    logic [ROW_W-1:0]    r_cur_row,  n_cur_row;
    logic                r_done,     n_done;
    logic [CHAR_W-1:0]   r_cell,     n_cell;
    logic [ROW_W-1:0]    r_drow,     n_drow;
    logic                r_found,    n_found;

    logic                mem_we;
    logic [ADDR_W-1:0]   mem_waddr;
    logic [CHAR_W-1:0]   mem_wdata;
    logic [ADDR_W-1:0]   mem_raddr;
    logic [CHAR_W-1:0]   mem_rdata;
    logic                accept;
    logic [ADDR_W-1:0]   cur_addr;
    logic [ADDR_W-1:0]   sel_addr;
    logic                sel_ok;

    // cell store
    tcb_ram #(
        .WIDTH (CHAR_W),
        .DEPTH (CELLS)
    ) u_cells (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign busy   = (r_state != ST_IDLE);
    assign accept = start && !busy;

    // cell addresses of the cursor and of the read select
    assign cur_addr = ADDR_W'(r_cur_row) * ADDR_W'(COLUMNS) + ADDR_W'(r_cur_col);
    assign sel_ok   = (32'(i_row_select) < ROWS) && (32'(i_column_select) < COLUMNS);
    assign sel_addr = ADDR_W'(i_row_select) * ADDR_W'(COLUMNS) + ADDR_W'(i_column_select);

    // state and control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_CLEAR;
            r_ptr     <= '0;
            r_pend    <= 1'b0;
            r_idx     <= '0;
            r_dirty   <= '1;
            r_cur_col <= '0;
            r_cur_row <= '0;
            r_done    <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_ptr     <= n_ptr;
            r_pend    <= n_pend;
            r_idx     <= n_idx;
            r_dirty   <= n_dirty;
            r_cur_col <= n_cur_col;
            r_cur_row <= n_cur_row;
            r_done    <= n_done;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_paddr <= n_paddr;
        r_cell  <= n_cell;
        r_drow  <= n_drow;
        r_found <= n_found;
    end

    // next state, cursor moves and ram accesses
    always_comb begin
        n_state   = r_state;
        n_ptr     = r_ptr;
        n_pend    = 1'b0;
        n_paddr   = r_paddr;
        n_idx     = r_idx;
        n_dirty   = r_dirty;
        n_cur_col = r_cur_col;
        n_cur_row = r_cur_row;
        n_done    = 1'b0;
        n_cell    = r_cell;
        n_drow    = r_drow;
        n_found   = r_found;
        mem_raddr = r_ptr;
        // a copied cell is written in the cycle after its read
        mem_we    = r_pend;
        mem_waddr = r_paddr;
        mem_wdata = mem_rdata;

        unique case (r_state)
            ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_ptr;
                mem_wdata = SPACE_CHAR;
                if (32'(r_ptr) == CELLS - 1) begin
                    n_ptr   = '0;
                    n_state = ST_IDLE;
                end else begin
                    n_ptr = r_ptr + 1'b1;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    n_cell  = '0;
                    n_drow  = '0;
                    n_found = 1'b0;
                    n_done  = 1'b1;
                    unique case (i_operation)
                        OP_PUT: begin
                            if (i_char_code != NUL_CHAR) begin
                                logic wrap;
                                wrap = 1'b0;
                                if (i_char_code == NEWLINE_CHAR) begin
                                    wrap = 1'b1;
                                end else begin
                                    mem_we             = 1'b1;
                                    mem_waddr          = cur_addr;
                                    mem_wdata          = i_char_code;
                                    n_dirty[r_cur_row] = 1'b1;
                                    if (r_cur_col == COL_W'(COLUMNS - 1)) begin
                                        wrap = 1'b1;
                                    end else begin
                                        n_cur_col = r_cur_col + 1'b1;
                                    end
                                end
                                // next line, scroll when past the last row
                                if (wrap) begin
                                    n_cur_col = '0;
                                    if (r_cur_row == ROW_W'(ROWS - 1)) begin
                                        n_dirty = '1;
                                        n_ptr   = ADDR_W'(COLUMNS);
                                        n_done  = 1'b0;
                                        n_state = ST_COPY;
                                    end else begin
                                        n_cur_row = r_cur_row + 1'b1;
                                    end
                                end
                            end
                        end
                        OP_READ: begin
                            if (sel_ok) begin
                                mem_raddr = sel_addr;
                                n_done    = 1'b0;
                                n_state   = ST_READ;
                            end
                        end
                        OP_TAKE: begin
                            n_idx   = '0;
                            n_done  = 1'b0;
                            n_state = ST_TAKE;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_READ: begin
                n_cell  = mem_rdata;
                n_done  = 1'b1;
                n_state = ST_IDLE;
            end
            ST_TAKE: begin
                // scan the dirty marks, lowest row first
                if (r_dirty[r_idx]) begin
                    n_dirty[r_idx] = 1'b0;
                    n_drow         = r_idx;
                    n_found        = 1'b1;
                    n_done         = 1'b1;
                    n_state        = ST_IDLE;
                end else if (r_idx == ROW_W'(ROWS - 1)) begin
                    n_done  = 1'b1;
                    n_state = ST_IDLE;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            ST_COPY: begin
                // read one row below, write back one row up next cycle
                mem_raddr = r_ptr;
                n_pend    = 1'b1;
                n_paddr   = r_ptr - ADDR_W'(COLUMNS);
                if (32'(r_ptr) == CELLS - 1) begin
                    n_ptr   = ADDR_W'((ROWS - 1) * COLUMNS);
                    n_state = ST_FILL;
                end else begin
                    n_ptr = r_ptr + 1'b1;
                end
            end
            ST_FILL: begin
                // blank the last row once the last copy has landed
                if (!r_pend) begin
                    mem_we    = 1'b1;
                    mem_waddr = r_ptr;
                    mem_wdata = SPACE_CHAR;
                    if (32'(r_ptr) == CELLS - 1) begin
                        n_ptr   = '0;
                        n_done  = 1'b1;
                        n_state = ST_IDLE;
                    end else begin
                        n_ptr = r_ptr + 1'b1;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // result ports
    assign o_done          = r_done;
    assign o_cell_char     = r_cell;
    assign o_dirty_row     = OUT_ROW_W'(r_drow);
    assign o_dirty_found   = r_found;
    assign o_cursor_column = OUT_COL_W'(r_cur_col);
    assign o_cursor_row    = OUT_ROW_W'(r_cur_row);

    // checks
    `TCB_ASSERT_NOW(a_done_idle, o_done, r_state == ST_IDLE, "result strobe outside idle")
    `TCB_ASSERT_NOW(a_pend_scroll, r_pend, r_state == ST_COPY || r_state == ST_FILL,
        "pending copy write outside a scroll")
    `TCB_ASSERT_NOW(a_cursor_range, 1'b1, 32'(r_cur_col) < COLUMNS && 32'(r_cur_row) < ROWS,
        "cursor outside the grid")
    `TCB_ASSERT_NEXT(a_take_scan, start && !busy && i_operation == OP_TAKE,
        r_state == ST_TAKE && r_idx == '0, "take item did not start a scan")

endmodule
